/* hdl/line_sensor_pid_steering_defines.svh */
// ----------------------------------------------------------------------------
// Line sensor PID steering assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_PID_STEERING_DEFINES_SVH
`define LINE_SENSOR_PID_STEERING_DEFINES_SVH

// same-cycle implication
`define LSPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lsps_pkg.sv */
// ----------------------------------------------------------------------------
// Line sensor PID steering package
// Widths, register map, reset values, config bundle and the pattern table.
// ----------------------------------------------------------------------------
`default_nettype none

package lsps_pkg;

  localparam int CHANNELS = 8;

  localparam int SENS_W  = 8;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 6;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PROD_W  = 22;
  localparam int DPROD_W = 23;
  localparam int INTEG_W = 18;
  localparam int SUM_W   = 24;
  localparam int DRIVE_W = 22;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_GAIN_P    = 3'd1;
  localparam logic [2:0] REG_GAIN_I    = 3'd2;
  localparam logic [2:0] REG_GAIN_D    = 3'd3;
  localparam logic [2:0] REG_LIMIT     = 3'd4;

  localparam logic [SENS_W-1:0] RST_THRESHOLD = 8'd126;
  localparam logic [GAIN_W-1:0] RST_GAIN_P    = 16'd8832;
  localparam logic [GAIN_W-1:0] RST_GAIN_I    = 16'd77;
  localparam logic [GAIN_W-1:0] RST_GAIN_D    = 16'd14080;
  localparam logic [GAIN_W-1:0] RST_LIMIT     = 16'd25600;

  typedef struct packed {
    logic [SENS_W-1:0] threshold;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] integral_limit;
  } cfg_t;

  typedef struct packed {
    logic                       valid;
    logic [CHANNELS-1:0]        pattern;
    logic signed [ERR_W-1:0]    error;
  } stage_t;

  // pattern to position error, half units; unlisted patterns map to zero
  function automatic logic signed [ERR_W-1:0] lookup_error(input logic [CHANNELS-1:0] pat);
    logic signed [ERR_W-1:0] e;
    case (pat)
      8'd127:  e = -6'sd12;
      8'd15:   e = -6'sd20;
      8'd7:    e = -6'sd20;
      8'd143:  e = -6'sd10;
      8'd63:   e = -6'sd16;
      8'd31:   e = -6'sd14;
      8'd159:  e = -6'sd4;
      8'd191:  e = -6'sd3;
      8'd207:  e = -6'sd2;
      8'd223:  e = -6'sd2;
      8'd240:  e = 6'sd20;
      8'd224:  e = 6'sd20;
      8'd248:  e = 6'sd14;
      8'd252:  e = 6'sd16;
      8'd254:  e = 6'sd12;
      8'd241:  e = 6'sd10;
      8'd249:  e = 6'sd4;
      8'd253:  e = 6'sd3;
      8'd243:  e = 6'sd2;
      8'd251:  e = 6'sd2;
      8'd239:  e = -6'sd1;
      8'd247:  e = 6'sd1;
      8'd231:  e = 6'sd0;
      default: e = 6'sd0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* hdl/lsps_if.sv */
// ----------------------------------------------------------------------------
// Line sensor PID steering channel interfaces
// Valid/ready channels for the sensor word and the steering result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsps_in_if
  import lsps_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SENS_W-1:0] sensor_0;
  logic [SENS_W-1:0] sensor_1;
  logic [SENS_W-1:0] sensor_2;
  logic [SENS_W-1:0] sensor_3;
  logic [SENS_W-1:0] sensor_4;
  logic [SENS_W-1:0] sensor_5;
  logic [SENS_W-1:0] sensor_6;
  logic [SENS_W-1:0] sensor_7;
  logic              sample_valid;

  modport source (output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
                  sensor_5, sensor_6, sensor_7, sample_valid, input ready);
  modport sink   (input valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
                  sensor_5, sensor_6, sensor_7, sample_valid, output ready);
endinterface

interface lsps_out_if
  import lsps_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic [CHANNELS-1:0]       line_pattern;
  logic signed [ERR_W-1:0]   position_error;

  modport source (output valid, drive, line_pattern, position_error, input ready);
  modport sink   (input valid, drive, line_pattern, position_error, output ready);
endinterface

`default_nettype wire

/* hdl/lsps_lane.sv */
// ----------------------------------------------------------------------------
// Sensor lane
// Thresholds one channel byte into one line pattern bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_lane
  import lsps_pkg::*;
(
  input  wire logic [SENS_W-1:0] sensor,
  input  wire logic [SENS_W-1:0] threshold,
  input  wire logic              sample_valid,
  output logic                   hit
);

  assign hit = sample_valid && (sensor > threshold);

endmodule

`default_nettype wire

/* hdl/lsps_merge.sv */
// ----------------------------------------------------------------------------
// Lane merge stage
// Registers the lane bits as the line pattern and looks up the position error.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_merge
  import lsps_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire logic [CHANNELS-1:0] lane_bits,
  output stage_t                   dn,
  input  wire logic                dn_ready
);

  logic                valid_r;
  logic [CHANNELS-1:0] pattern_r;

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pattern_r <= lane_bits;
    end
  end

  assign dn.valid   = valid_r;
  assign dn.pattern = pattern_r;
  assign dn.error   = lookup_error(pattern_r);

endmodule

`default_nettype wire

/* hdl/lsps_pid.sv */
// ----------------------------------------------------------------------------
// PID pipeline
// Gain products, integral update with clamp, and the final drive sum.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_pid
  import lsps_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire stage_t up,
  output logic        up_ready,
  lsps_out_if.source  out_ch
);

  // product stage
  logic                      v2_r;
  logic [CHANNELS-1:0]       pat2_r;
  logic signed [ERR_W-1:0]   err2_r;
  logic signed [PROD_W-1:0]  pprod_r;
  logic signed [PROD_W-1:0]  iprod_r;
  logic signed [DPROD_W-1:0] dprod_r;
  logic signed [ERR_W-1:0]   last_error_r;

  // integral stage
  logic                      v3_r;
  logic [CHANNELS-1:0]       pat3_r;
  logic signed [ERR_W-1:0]   err3_r;
  logic signed [SUM_W-1:0]   pd_r;
  logic signed [INTEG_W-1:0] integral_r;

  // output stage
  logic                      v4_r;
  logic [CHANNELS-1:0]       pat4_r;
  logic signed [ERR_W-1:0]   err4_r;
  logic signed [DRIVE_W-1:0] drive_r;

  logic ready2, ready3, ready4;
  logic load2, load3, load4;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [GAIN_W:0]    gp_s, gi_s, gd_s;
  logic signed [PROD_W-1:0]  pprod_nxt, iprod_nxt;
  logic signed [DPROD_W-1:0] dprod_nxt;

  logic signed [PROD_W-1:0]  ihalf;
  logic signed [PROD_W-1:0]  isum;
  logic signed [PROD_W-1:0]  lim;
  logic signed [PROD_W-1:0]  isum_c;
  logic signed [SUM_W-1:0]   pd_nxt;
  logic signed [SUM_W-1:0]   drive_sum;

  assign ready4   = !v4_r || out_ch.ready;
  assign ready3   = !v3_r || ready4;
  assign ready2   = !v2_r || ready3;
  assign up_ready = ready2;

  assign load2 = ready2 && up.valid;
  assign load3 = ready3 && v2_r;
  assign load4 = ready4 && v3_r;

  assign gp_s = $signed({1'b0, cfg.gain_p});
  assign gi_s = $signed({1'b0, cfg.gain_i});
  assign gd_s = $signed({1'b0, cfg.gain_d});
  assign diff = DIFF_W'(up.error) - DIFF_W'(last_error_r);

  assign pprod_nxt = gp_s * up.error;
  assign iprod_nxt = gi_s * up.error;
  assign dprod_nxt = gd_s * diff;

  assign ihalf  = iprod_r >>> 1;
  assign isum   = PROD_W'(integral_r) + ihalf;
  assign lim    = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.integral_limit});
  assign pd_nxt = SUM_W'(pprod_r >>> 1) + SUM_W'(dprod_r >>> 1);

  always_comb begin
    if (isum > lim) begin
      isum_c = lim;
    end else if (isum < -lim) begin
      isum_c = -lim;
    end else begin
      isum_c = isum;
    end
  end

  assign drive_sum = pd_r + SUM_W'(integral_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      last_error_r <= '0;
      integral_r   <= '0;
    end else begin
      if (ready2) begin
        v2_r <= up.valid;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
      if (ready4) begin
        v4_r <= v3_r;
      end
      if (load2) begin
        last_error_r <= up.error;
      end
      if (load3) begin
        integral_r <= isum_c[INTEG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      pat2_r  <= up.pattern;
      err2_r  <= up.error;
      pprod_r <= pprod_nxt;
      iprod_r <= iprod_nxt;
      dprod_r <= dprod_nxt;
    end
    if (load3) begin
      pat3_r <= pat2_r;
      err3_r <= err2_r;
      pd_r   <= pd_nxt;
    end
    if (load4) begin
      pat4_r  <= pat3_r;
      err4_r  <= err3_r;
      drive_r <= drive_sum[DRIVE_W-1:0];
    end
  end

  assign out_ch.valid          = v4_r;
  assign out_ch.drive          = drive_r;
  assign out_ch.line_pattern   = pat4_r;
  assign out_ch.position_error = err4_r;

endmodule

`default_nettype wire

/* hdl/line_sensor_pid_steering.sv */
// ----------------------------------------------------------------------------
// Line sensor PID steering
// Thresholds eight sensor bytes, maps the line pattern to a position error
// and runs a PID step to produce a Q8 steering drive.
// ----------------------------------------------------------------------------
// One sensor word is taken every clock cycle unless the output stalls; each
// gives one result word via lane compare into the pattern register, gain
// products, integral clamp, drive sum. Integral and last error state advance
// once per accepted word, in order, so back-to-back words see the state left
// by the word before. The user must write registers over the APB port only
// while no words are in flight (not enforced); reads return current values.
`default_nettype none

module line_sensor_pid_steering
  import lsps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  lsps_in_if.sink                in_ch,
  lsps_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t                cfg_r;
  logic [2:0]          reg_idx;
  logic                wr_en;
  logic [SENS_W-1:0]   sens [CHANNELS];
  logic [CHANNELS-1:0] lane_bits;
  stage_t              s1;
  logic                s1_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= RST_THRESHOLD;
      cfg_r.gain_p         <= RST_GAIN_P;
      cfg_r.gain_i         <= RST_GAIN_I;
      cfg_r.gain_d         <= RST_GAIN_D;
      cfg_r.integral_limit <= RST_LIMIT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: cfg_r.threshold      <= pwdata[SENS_W-1:0];
        REG_GAIN_P:    cfg_r.gain_p         <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    cfg_r.gain_i         <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    cfg_r.gain_d         <= pwdata[GAIN_W-1:0];
        REG_LIMIT:     cfg_r.integral_limit <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = DATA_W'(cfg_r.threshold);
      REG_GAIN_P:    prdata = DATA_W'(cfg_r.gain_p);
      REG_GAIN_I:    prdata = DATA_W'(cfg_r.gain_i);
      REG_GAIN_D:    prdata = DATA_W'(cfg_r.gain_d);
      REG_LIMIT:     prdata = DATA_W'(cfg_r.integral_limit);
      default:       prdata = '0;
    endcase
  end

  assign sens[0] = in_ch.sensor_0;
  assign sens[1] = in_ch.sensor_1;
  assign sens[2] = in_ch.sensor_2;
  assign sens[3] = in_ch.sensor_3;
  assign sens[4] = in_ch.sensor_4;
  assign sens[5] = in_ch.sensor_5;
  assign sens[6] = in_ch.sensor_6;
  assign sens[7] = in_ch.sensor_7;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    lsps_lane u_lane (
      .sensor       (sens[g]),
      .threshold    (cfg_r.threshold),
      .sample_valid (in_ch.sample_valid),
      .hit          (lane_bits[g])
    );
  end

  lsps_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_ch.valid),
    .up_ready  (in_ch.ready),
    .lane_bits (lane_bits),
    .dn        (s1),
    .dn_ready  (s1_ready)
  );

  lsps_pid u_pid (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up       (s1),
    .up_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

/* hdl/lsps_checker.sv */
// ----------------------------------------------------------------------------
// Line sensor PID steering port checker
// Watches the result channel and the config port of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_sensor_pid_steering_defines.svh"

module lsps_checker
  import lsps_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [DRIVE_W-1:0] out_drive,
  input wire logic [CHANNELS-1:0]       out_pattern,
  input wire logic signed [ERR_W-1:0]   out_error,
  input wire logic                      pready
);

  `LSPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive) && $stable(out_pattern) && $stable(out_error), "result word changed while stalled")
  `LSPS_ASSERT_IMPLY(a_blank_err, out_valid && (out_pattern == '0 || out_pattern == '1), out_error == 6'sd0, "blank or full pattern gave nonzero error")
  `LSPS_ASSERT_IMPLY(a_err_range, out_valid, (out_error >= -6'sd20) && (out_error <= 6'sd20), "position error out of range")
  `LSPS_ASSERT_IMPLY(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind line_sensor_pid_steering lsps_checker u_lsps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_drive   (out_ch.drive),
  .out_pattern (out_ch.line_pattern),
  .out_error   (out_ch.position_error),
  .pready      (pready)
);

`default_nettype wire

/* dv/line_sensor_pid_steering_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor PID steering testbench
// Streams sensor words through the block under several register settings and
// idle patterns, predicts or looks up each steering word, compares whole
// words in arrival order and reads register writes back over APB.
// ----------------------------------------------------------------------------

module line_sensor_pid_steering_tb
  import lsps_pkg::*;
;

  localparam int PHASES    = 7;
  localparam int MAP_SIZE  = 23;
  localparam int MAX_SHOWN = 10;

  localparam logic [2:0] REG_UNMAPPED = 3'd6;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [CHANNELS-1:0][SENS_W-1:0] sens;
    logic                            sample_valid;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [CHANNELS-1:0]       line_pattern;
    logic signed [ERR_W-1:0]   position_error;
  } steer_t;

  typedef struct packed {
    sample_t smp;
    logic    known;
    steer_t  want;
  } row_t;

  localparam logic [7:0] LINE_CODES [MAP_SIZE] = '{
    8'd127, 8'd15, 8'd7, 8'd143, 8'd63, 8'd31, 8'd159, 8'd191, 8'd207, 8'd223,
    8'd240, 8'd224, 8'd248, 8'd252, 8'd254, 8'd241, 8'd249, 8'd253, 8'd243,
    8'd251, 8'd239, 8'd247, 8'd231
  };
  localparam int LINE_OFFSETS [MAP_SIZE] = '{
    -12, -20, -20, -10, -16, -14, -4, -3, -2, -2,
    20, 20, 14, 16, 12, 10, 4, 3, 2, 2,
    -1, 1, 0
  };

  // threshold 126 at reset: 7F reads set, 7E reads clear
  localparam int RUN_IN_LEN = 20;
  localparam row_t RUN_IN [RUN_IN_LEN] = '{
    '{'{64'h0000000000000000, 1'b1}, 1'b1, '{22'sd0, 8'h00, 6'sd0}},
    '{'{64'hFFFFFFFFFFFFFFFF, 1'b0}, 1'b1, '{22'sd0, 8'h00, 6'sd0}},
    '{'{64'hFFFFFFFFFFFFFFFF, 1'b1}, 1'b1, '{22'sd0, 8'hFF, 6'sd0}},
    '{'{64'h7F7F7F7F7E7E7E7E, 1'b1}, 1'b0, '0},
    '{'{64'h0000000000FFFFFF, 1'b1}, 1'b0, '0},
    '{'{64'h00FFFFFFFFFFFFFF, 1'b1}, 1'b0, '0},
    '{'{64'hFFFFFF0000FFFFFF, 1'b1}, 1'b0, '0},
    '{'{64'hFFFFFFFF00000000, 1'b0}, 1'b0, '0},
    '{'{64'h00000000FFFFFFFF, 1'b1}, 1'b0, '0},
    '{'{64'hFFFFFF0000000000, 1'b1}, 1'b0, '0},
    '{'{64'h00FF00FF00FF00FF, 1'b1}, 1'b0, '0},
    '{'{64'hFF000000FFFFFFFF, 1'b1}, 1'b0, '0},
    '{'{64'hFFFFFFFFFFFFFF00, 1'b1}, 1'b0, '0},
    '{'{64'hFFFFFF00FFFFFFFF, 1'b1}, 1'b0, '0},
    '{'{64'hFFFFFFFF00FFFFFF, 1'b1}, 1'b0, '0},
    '{'{64'h0000FFFFFFFFFFFF, 1'b1}, 1'b0, '0},
    '{'{64'hFFFFFFFFFFFF0000, 1'b1}, 1'b0, '0},
    '{'{64'h7F7E7E7E7E7E7E7E, 1'b1}, 1'b0, '0},
    '{'{64'hFFFFFFFF00000000, 1'b1}, 1'b0, '0},
    '{'{64'h0000000000FFFFFF, 1'b1}, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lsps_in_if  in_ch ();
  lsps_out_if out_ch ();

  line_sensor_pid_steering i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t    ctl = '{RST_THRESHOLD, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_LIMIT};
  longint  integ_acc = 0;
  longint  prev_err = 0;
  steer_t  steer_q [$];
  int      send_idle = 0;
  int      recv_stall = 0;
  int      fail_count = 0;
  int      words_sent = 0;
  int      words_seen = 0;
  steer_t  rx_word;
  steer_t  rx_want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void flag(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("MISMATCH: %s", msg);
  endfunction

  function automatic logic [DATA_W-1:0] ctl_field(input cfg_t c, input logic [2:0] idx);
    case (idx)
      REG_THRESHOLD: return DATA_W'(c.threshold);
      REG_GAIN_P:    return DATA_W'(c.gain_p);
      REG_GAIN_I:    return DATA_W'(c.gain_i);
      REG_GAIN_D:    return DATA_W'(c.gain_d);
      REG_LIMIT:     return DATA_W'(c.integral_limit);
      default:       return '0;
    endcase
  endfunction

  function automatic void ctl_write(input logic [2:0] idx, input logic [DATA_W-1:0] v);
    case (idx)
      REG_THRESHOLD: ctl.threshold      = v[SENS_W-1:0];
      REG_GAIN_P:    ctl.gain_p         = v[GAIN_W-1:0];
      REG_GAIN_I:    ctl.gain_i         = v[GAIN_W-1:0];
      REG_GAIN_D:    ctl.gain_d         = v[GAIN_W-1:0];
      REG_LIMIT:     ctl.integral_limit = v[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // threshold, table lookup, then one PID update of the bench state
  function automatic steer_t pid_step(input sample_t s);
    steer_t           r;
    logic [CHANNELS-1:0] pat;
    longint           e, d, lim, acc, drv;
    int               c, k;
    pat = '0;
    if (s.sample_valid)
      for (c = 0; c < CHANNELS; c++)
        if (s.sens[c] > ctl.threshold) pat[c] = 1'b1;
    e = 0;
    for (k = 0; k < MAP_SIZE; k++)
      if (LINE_CODES[k] == pat) e = longint'(LINE_OFFSETS[k]);
    d   = e - prev_err;
    lim = longint'(ctl.integral_limit);
    acc = integ_acc + ((longint'(ctl.gain_i) * e) >>> 1);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    drv = ((longint'(ctl.gain_p) * e) >>> 1) + acc + ((longint'(ctl.gain_d) * d) >>> 1);
    integ_acc = acc;
    prev_err  = e;
    r.drive          = drv[DRIVE_W-1:0];
    r.line_pattern   = pat;
    r.position_error = e[ERR_W-1:0];
    return r;
  endfunction

  // mostly clean table patterns under the current threshold, some raw noise
  function automatic sample_t make_sample();
    sample_t             s;
    logic [CHANNELS-1:0] target;
    int                  c, thr;
    thr = int'(ctl.threshold);
    s.sample_valid = ($urandom_range(9) != 0);
    if ($urandom_range(99) < 15) begin
      for (c = 0; c < CHANNELS; c++) s.sens[c] = SENS_W'($urandom_range(255));
      return s;
    end
    if ($urandom_range(9) < 8) target = LINE_CODES[$urandom_range(MAP_SIZE - 1)];
    else target = CHANNELS'($urandom_range(255));
    for (c = 0; c < CHANNELS; c++)
      if (target[c] && thr < 255) s.sens[c] = SENS_W'($urandom_range(255, thr + 1));
      else s.sens[c] = SENS_W'($urandom_range(thr));
    return s;
  endfunction

  function automatic cfg_t phase_setting(input int p);
    cfg_t c;
    c.threshold      = SENS_W'($urandom_range(255));
    c.gain_p         = GAIN_W'($urandom_range(65535));
    c.gain_i         = GAIN_W'($urandom_range(65535));
    c.gain_d         = GAIN_W'($urandom_range(65535));
    c.integral_limit = GAIN_W'($urandom_range(65535));
    case (p)
      1: c = '{8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      2: c = '{8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
      3: c.integral_limit = GAIN_W'($urandom_range(2000));
      4: begin
        c.gain_i         = 16'hFFFF;
        c.integral_limit = 16'h0000;
      end
      6: c = '{RST_THRESHOLD, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_LIMIT};
      default: ;
    endcase
    return c;
  endfunction

  task automatic reg_access(input logic wr, input logic [2:0] idx,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) ctl_write(idx, wdata);
  endtask

  task automatic check_registers();
    logic [DATA_W-1:0] rd;
    int                r;
    for (r = int'(REG_THRESHOLD); r <= int'(REG_LIMIT); r++) begin
      reg_access(1'b0, r[2:0], '0, rd);
      if (rd !== ctl_field(ctl, r[2:0]))
        flag($sformatf("register %0d read %0h, expected %0h", r, rd, ctl_field(ctl, r[2:0])));
    end
  endtask

  task automatic program_setting(input cfg_t c);
    logic [DATA_W-1:0] rd;
    int                r;
    for (r = int'(REG_THRESHOLD); r <= int'(REG_LIMIT); r++)
      reg_access(1'b1, r[2:0], ctl_field(c, r[2:0]), rd);
  endtask

  // stop sending and wait until every steering word is back
  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (steer_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_sample(input sample_t s, input logic known, input steer_t want);
    steer_t guess;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sensor_0     <= s.sens[0];
    in_ch.sensor_1     <= s.sens[1];
    in_ch.sensor_2     <= s.sens[2];
    in_ch.sensor_3     <= s.sens[3];
    in_ch.sensor_4     <= s.sens[4];
    in_ch.sensor_5     <= s.sens[5];
    in_ch.sensor_6     <= s.sens[6];
    in_ch.sensor_7     <= s.sens[7];
    in_ch.sample_valid <= s.sample_valid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    guess = pid_step(s);
    steer_q.push_back(known ? want : guess);
    words_sent++;
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_word = '{out_ch.drive, out_ch.line_pattern, out_ch.position_error};
      words_seen++;
      if (steer_q.size() == 0) begin
        flag($sformatf("steering word %0d with nothing pending: drive %0d pattern %02h error %0d",
                       words_seen, rx_word.drive, rx_word.line_pattern,
                       rx_word.position_error));
      end else begin
        rx_want = steer_q.pop_front();
        if (rx_word !== rx_want)
          flag($sformatf({"word %0d: expected drive %0d pattern %02h error %0d,",
                          " got drive %0d pattern %02h error %0d"},
                         words_seen, rx_want.drive, rx_want.line_pattern,
                         rx_want.position_error, rx_word.drive, rx_word.line_pattern,
                         rx_word.position_error));
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] rd;
    idle_mode_t        mode;
    int                p, n, count;
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.sensor_0     <= '0;
    in_ch.sensor_1     <= '0;
    in_ch.sensor_2     <= '0;
    in_ch.sensor_3     <= '0;
    in_ch.sensor_4     <= '0;
    in_ch.sensor_5     <= '0;
    in_ch.sensor_6     <= '0;
    in_ch.sensor_7     <= '0;
    in_ch.sample_valid <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < PHASES; p++) begin
      mode = idle_mode_t'(p % 4);
      send_idle  = (mode == IDLE_SEND) ? 86 : (mode == IDLE_BOTH) ? 12 : 0;
      recv_stall = (mode == IDLE_RECV) ? 86 : (mode == IDLE_BOTH) ? 12 : 0;
      if (p > 0) begin
        drain(6);
        program_setting(phase_setting(p));
        if (p == 3) reg_access(1'b1, REG_UNMAPPED, $urandom, rd);
      end
      check_registers();
      if (p == 0)
        for (n = 0; n < RUN_IN_LEN; n++)
          send_sample(RUN_IN[n].smp, RUN_IN[n].known, RUN_IN[n].want);
      count = (p == 2) ? 60 : 250;
      for (n = 0; n < count; n++) begin
        if (n == count / 2) drain(0);
        send_sample(make_sample(), 1'b0, '0);
      end
    end

    drain(8);
    $display("Run covered %0d sensor words over %0d register settings and four idle mixes;",
             words_sent, PHASES);
    $display("%0d steering words checked, %0d mismatches", words_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
